### design/kper_pkg.sv
// Shared types and constants for the keypad event repeat / long press detector.
package kper_pkg;

    localparam int KEY_W  = 5;
    localparam int TIME_W = 32;
    localparam int THR_W  = 16;
    localparam int CODE_W = 8;
    localparam int GPIO_W = 5;

    // Configuration register indexes
    localparam logic [1:0] CFG_LONG_THR = 2'd0;
    localparam logic [1:0] CFG_REP_INT  = 2'd1;
    localparam logic [1:0] CFG_GPIO_IDX = 2'd2;

    // Configuration reset values
    localparam logic [THR_W-1:0]  LONG_THR_RST = 16'd500;
    localparam logic [THR_W-1:0]  REP_INT_RST  = 16'd200;
    localparam logic [GPIO_W-1:0] GPIO_IDX_RST = 5'd5;

    // Event code layout
    localparam int         PRESS_BIT     = 7;
    localparam logic [6:0] GPIO_CODE_MIN = 7'd97;
    localparam logic [3:0] MATRIX_PITCH  = 4'd10;

    // Divide by ten as multiply by 205 and shift by 11 (exact below 1024)
    localparam logic [14:0] DIV10_MUL   = 15'd205;
    localparam int          DIV10_SHIFT = 11;

    typedef enum logic [2:0] {
        EV_PRESS   = 3'd0,
        EV_RELEASE = 3'd1,
        EV_SHORT   = 3'd2,
        EV_REPEAT  = 3'd3,
        EV_LONG    = 3'd4
    } ev_kind_t;

    typedef struct packed {
        logic [KEY_W-1:0] idx;
        ev_kind_t         kind;
    } ev_t;

    // Sequencer to emitter
    typedef struct packed {
        logic push;
        logic flush;
        ev_t  ev;
    } emit_req_t;

    // Emitter to sequencer
    typedef struct packed {
        logic can_take;
        logic hold_vld;
    } emit_sts_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EVT   = 7'b0000010,
        S_RD    = 7'b0000100,
        S_CHK   = 7'b0001000,
        S_EMIT0 = 7'b0010000,
        S_EMIT1 = 7'b0100000,
        S_FLUSH = 7'b1000000
    } walk_state_t;

endpackage

### design/kper_slot_dec.sv
// Key event code to matrix slot decoder with range check.
module kper_slot_dec
    import kper_pkg::*;
#(
    parameter int ROWS   = 5,
    parameter int COLS   = 6,
    parameter int NSLOTS = 30
) (
    input  logic [6:0]        key_num,
    input  logic [GPIO_W-1:0] gpio_idx,
    output logic [KEY_W-1:0]  slot,
    output logic              ok
);

    logic [6:0]  km1;
    logic [14:0] prod;
    logic [3:0]  row;
    logic [6:0]  col_w;
    logic [3:0]  col;
    logic [6:0]  mat_slot;
    logic        mat_ok;
    logic        gpio_ok;
    logic        is_gpio;

    // Split key number minus one into row and column of a ten wide grid
    always_comb
    begin
        km1      = key_num - 7'd1;
        prod     = {8'b0, km1} * DIV10_MUL;
        row      = prod[DIV10_SHIFT +: 4];
        col_w    = km1 - (7'(row) * 7'(MATRIX_PITCH));
        col      = col_w[3:0];
        mat_slot = 7'(col) + 7'(row) * 7'(COLS);
        mat_ok   = (key_num != 7'd0) && (row < 4'(ROWS)) && (col < 4'(COLS))
                   && (mat_slot < 7'(NSLOTS));
        gpio_ok  = {1'b0, gpio_idx} < 6'(NSLOTS);
        is_gpio  = key_num >= GPIO_CODE_MIN;
    end

    // Pick the source of the slot
    always_comb
    begin
        if (is_gpio)
        begin
            slot = gpio_idx;
            ok   = gpio_ok;
        end
        else
        begin
            slot = mat_slot[KEY_W-1:0];
            ok   = mat_ok;
        end
    end

endmodule

### design/kper_emit.sv
// Result emitter: one-deep hold stage that marks the final beat of a scan, then output register.
module kper_emit
    import kper_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  emit_req_t        req,
    output emit_sts_t        sts,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [KEY_W-1:0] key_index,
    output logic [2:0]       event_kind,
    output logic             last
);

    logic hold_vld_reg;
    ev_t  hold_reg;
    logic out_vld_reg;
    ev_t  out_ev_reg;
    logic out_last_reg;
    logic can_take;
    logic load_out;

    // Hold takes a new event when empty or when its content can move out
    always_comb
    begin
        can_take = !hold_vld_reg || !out_vld_reg || out_ready;
        load_out = (req.push || req.flush) && can_take && hold_vld_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (req.push && can_take)
                hold_vld_reg <= 1'b1;
            else if (req.flush && can_take)
                hold_vld_reg <= 1'b0;

            if (load_out)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    // Payload: a flush moves the held event out as the final beat
    always_ff @(posedge clk)
    begin
        if (req.push && can_take)
            hold_reg <= req.ev;
        if (load_out)
        begin
            out_ev_reg   <= hold_reg;
            out_last_reg <= req.flush;
        end
    end

    assign sts.can_take = can_take;
    assign sts.hold_vld = hold_vld_reg;
    assign out_valid    = out_vld_reg;
    assign key_index    = out_ev_reg.idx;
    assign event_kind   = out_ev_reg.kind;
    assign last         = out_last_reg;

endmodule

### design/keypad_event_repeat_long_press_top.sv
// Top level: key auto-repeat and long press detector with slot time memory and walk sequencer.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  in       | input     | in_valid / in_ready  | cmd, event_code, time_ms
//  out      | output    | out_valid / out_ready| key_index, event_kind, last
//  cfg      | input     | cfg_we               | cfg_index, cfg_wdata
//
// A scan walks every slot in turn, after first applying a carried event code; each key that
// reports passes through an emit state per result beat and, below the last slot, returns to the
// read state to re-read the time memory, whose single read port is walked one slot per cycle
// while no key reports. A carried code off the matrix ends the scan with no result.
// Reset clears the key flags and the memory valid bits; no clearing pass is needed.
// A stalled output holds the walk at the next result beat; the final beat may wait there.
module keypad_event_repeat_long_press_top
    import kper_pkg::*;
#(
    parameter int ROWS = 5,
    parameter int COLS = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [THR_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [CODE_W-1:0] event_code,
    input  logic [TIME_W-1:0] time_ms,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [KEY_W-1:0]  key_index,
    output logic [2:0]        event_kind,
    output logic              last
);

    localparam int NSLOTS = ((ROWS * COLS) > 32) ? 32 : (ROWS * COLS);
    localparam int SLOT_W = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NSLOTS - 1);

    walk_state_t         state_reg, state_next;
    logic [SLOT_W-1:0]   cnt_reg, cnt_next;
    logic [CODE_W-1:0]   code_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [THR_W-1:0]    long_thr_reg;
    logic [THR_W-1:0]    rep_int_reg;
    logic [GPIO_W-1:0]   gpio_idx_reg;
    logic [NSLOTS-1:0]   is_down_reg, is_down_next;
    logic [NSLOTS-1:0]   was_down_reg, was_down_next;
    logic [NSLOTS-1:0]   long_rep_reg, long_rep_next;
    logic [NSLOTS-1:0]   tvld_reg;
    ev_t                 ev0_reg, ev0_next;
    ev_t                 ev1_reg, ev1_next;
    logic                ev1_vld_reg, ev1_vld_next;
    logic                ev0_vld;

    // Slot time memory: {first_press_time, last_repeat_time}
    logic [2*TIME_W-1:0] tmem [NSLOTS];
    logic [2*TIME_W-1:0] tmem_rdata_reg;
    logic                rd_vld_reg;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    logic [2*TIME_W-1:0] mem_wdata;
    logic [SLOT_W-1:0]   mem_raddr;

    logic [KEY_W-1:0]    dec_slot;
    logic                dec_ok;
    logic [SLOT_W-1:0]   dec_sidx;
    logic                press;

    logic [TIME_W-1:0]   fpt;
    logic [TIME_W-1:0]   lrt;
    logic [TIME_W-1:0]   d_first;
    logic [TIME_W-1:0]   d_rep;
    logic                is_short;
    logic                is_rep;
    logic                long_due;
    logic                cur_dn;
    logic                cur_was;
    logic                cur_lr;
    logic                last_slot;

    emit_req_t           emit_req;
    emit_sts_t           emit_sts;

    kper_slot_dec #(
        .ROWS   (ROWS),
        .COLS   (COLS),
        .NSLOTS (NSLOTS)
    ) u_slot_dec (
        .key_num  (code_reg[6:0]),
        .gpio_idx (gpio_idx_reg),
        .slot     (dec_slot),
        .ok       (dec_ok)
    );

    kper_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (emit_req),
        .sts        (emit_sts),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .key_index  (key_index),
        .event_kind (event_kind),
        .last       (last)
    );

    assign dec_sidx  = dec_slot[SLOT_W-1:0];
    assign press     = code_reg[PRESS_BIT];
    assign in_ready  = (state_reg == S_IDLE);
    assign last_slot = (cnt_reg == LAST_SLOT);

    // Time checks on the entry read for the current slot; unwritten entries read as zero
    always_comb
    begin
        fpt      = rd_vld_reg ? tmem_rdata_reg[TIME_W +: TIME_W] : '0;
        lrt      = rd_vld_reg ? tmem_rdata_reg[0 +: TIME_W] : '0;
        d_first  = now_reg - fpt;
        d_rep    = now_reg - lrt;
        is_short = d_first < {{(TIME_W-THR_W){1'b0}}, long_thr_reg};
        is_rep   = d_rep > {{(TIME_W-THR_W){1'b0}}, rep_int_reg};
        cur_dn   = is_down_reg[cnt_reg];
        cur_was  = was_down_reg[cnt_reg];
        cur_lr   = long_rep_reg[cnt_reg];
        long_due = !is_short && !cur_lr;
    end

    // Work out up to two events for the current slot
    always_comb
    begin
        ev0_vld         = 1'b0;
        ev0_next.idx    = KEY_W'(cnt_reg);
        ev0_next.kind   = EV_PRESS;
        ev1_next.idx    = KEY_W'(cnt_reg);
        ev1_next.kind   = EV_LONG;
        ev1_vld_next    = 1'b0;
        if (cur_dn != cur_was)
        begin
            ev0_vld = 1'b1;
            if (cur_dn)
            begin
                ev0_next.kind = EV_PRESS;
            end
            else
            begin
                ev0_next.kind = EV_RELEASE;
                ev1_next.kind = EV_SHORT;
                ev1_vld_next  = is_short;
            end
        end
        else if (cur_dn)
        begin
            if (is_rep)
            begin
                ev0_vld       = 1'b1;
                ev0_next.kind = EV_REPEAT;
                ev1_vld_next  = long_due;
            end
            else if (long_due)
            begin
                ev0_vld       = 1'b1;
                ev0_next.kind = EV_LONG;
            end
        end
    end

    // Walk sequencer: apply event, then read, check, write back and emit per slot
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        is_down_next  = is_down_reg;
        was_down_next = was_down_reg;
        long_rep_next = long_rep_reg;
        mem_we        = 1'b0;
        mem_waddr     = cnt_reg;
        mem_wdata     = {fpt, now_reg};
        emit_req      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cmd ? S_EVT : S_RD;
                    cnt_next   = '0;
                end
            end
            S_EVT:
            begin
                if (!dec_ok)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    is_down_next[dec_sidx] = press;
                    if (press)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = dec_sidx;
                        mem_wdata = {now_reg, now_reg};
                    end
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                was_down_next[cnt_reg] = cur_dn;
                if ((cur_dn != cur_was) && cur_dn)
                    long_rep_next[cnt_reg] = 1'b0;
                else if ((cur_dn == cur_was) && cur_dn && long_due)
                    long_rep_next[cnt_reg] = 1'b1;
                if ((cur_dn == cur_was) && cur_dn && is_rep)
                    mem_we = 1'b1;
                if (ev0_vld)
                    state_next = S_EMIT0;
                else if (last_slot)
                    state_next = S_FLUSH;
                else
                    cnt_next = cnt_reg + SLOT_W'(1);
            end
            S_EMIT0:
            begin
                emit_req.push = 1'b1;
                emit_req.ev   = ev0_reg;
                if (emit_sts.can_take)
                begin
                    if (ev1_vld_reg)
                        state_next = S_EMIT1;
                    else if (last_slot)
                        state_next = S_FLUSH;
                    else
                    begin
                        cnt_next   = cnt_reg + SLOT_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_EMIT1:
            begin
                emit_req.push = 1'b1;
                emit_req.ev   = ev1_reg;
                if (emit_sts.can_take)
                begin
                    if (last_slot)
                        state_next = S_FLUSH;
                    else
                    begin
                        cnt_next   = cnt_reg + SLOT_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_FLUSH:
            begin
                emit_req.flush = 1'b1;
                if (emit_sts.can_take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Read the slot the walk looks at next; a write never hits an entry read before it lands
    assign mem_raddr = cnt_next;

    // Control state, key flags and memory valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            is_down_reg  <= '0;
            was_down_reg <= '0;
            long_rep_reg <= '0;
            tvld_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            ev1_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            is_down_reg  <= is_down_next;
            was_down_reg <= was_down_next;
            long_rep_reg <= long_rep_next;
            if (mem_we)
                tvld_reg[mem_waddr] <= 1'b1;
            rd_vld_reg <= tvld_reg[mem_raddr];
            if (state_reg == S_CHK)
                ev1_vld_reg <= ev1_vld_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_thr_reg <= LONG_THR_RST;
            rep_int_reg  <= REP_INT_RST;
            gpio_idx_reg <= GPIO_IDX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LONG_THR: long_thr_reg <= cfg_wdata;
                CFG_REP_INT:  rep_int_reg  <= cfg_wdata;
                CFG_GPIO_IDX: gpio_idx_reg <= cfg_wdata[GPIO_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Scan payload and pending events
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            code_reg <= event_code;
            now_reg  <= time_ms;
        end
        if (state_reg == S_CHK)
        begin
            ev0_reg <= ev0_next;
            ev1_reg <= ev1_next;
        end
    end

    // Slot time memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            tmem[mem_waddr] <= mem_wdata;
        tmem_rdata_reg <= tmem[mem_raddr];
    end

`ifndef SYNTHESIS
    // A scan never ends with an event still held back from the output
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !emit_sts.hold_vld)
        else $error("event left in hold stage at end of scan");

    // Check only sees memory data that was read for the current slot
    a_chk_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> ($past(state_reg) == S_RD || $past(state_reg) == S_CHK))
        else $error("slot check without a matching memory read");

    // Second event beat only when one was found
    a_emit1_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT1) |-> ev1_vld_reg)
        else $error("second event emitted without a pending event");

    // Walk counter stays within the slot range
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_SLOT)
        else $error("walk counter past last slot");
`endif

endmodule

### tb/keypad_event_checker.sv
// Event checker: predicts key events for every scan beat and compares result beats in order.
module keypad_event_checker
    import kper_pkg::*;
#(
    parameter int ROWS = 5,
    parameter int COLS = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [THR_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              cmd,
    input  logic [CODE_W-1:0] event_code,
    input  logic [TIME_W-1:0] time_ms,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [KEY_W-1:0]  key_index,
    input  logic [2:0]        event_kind,
    input  logic              last,
    output int                mismatches,
    output int                outstanding,
    output int                beats_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = (ROWS * COLS > 32) ? 32 : ROWS * COLS;

    typedef struct packed {
        logic [KEY_W-1:0] idx;
        ev_kind_t         kind;
        logic             last;
    } event_beat_t;

    // Register copies
    logic [THR_W-1:0]  long_thr  = LONG_THR_RST;
    logic [THR_W-1:0]  rep_int   = REP_INT_RST;
    logic [GPIO_W-1:0] gpio_slot = GPIO_IDX_RST;

    // Per-key state
    logic [TIME_W-1:0] press_t  [NSLOT];
    logic [TIME_W-1:0] repeat_t [NSLOT];
    logic              key_down [NSLOT];
    logic              key_seen [NSLOT];
    logic              long_done[NSLOT];

    event_beat_t pending_events[$];
    event_beat_t staged;
    bit          have_staged = 1'b0;
    int          err_count   = 0;
    int          beat_count  = 0;

    // Queue the previously staged event and stage a new one; the last one gets the end flag
    task automatic stage_beat(input int slot, input ev_kind_t kind);
        if (have_staged)
            pending_events.push_back(staged);
        staged.idx  = KEY_W'(slot);
        staged.kind = kind;
        staged.last = 1'b0;
        have_staged = 1'b1;
    endtask

    // Apply the optional key event, then walk every key and queue the events it reports
    task automatic predict_events(input logic has_code, input logic [CODE_W-1:0] code,
                                  input logic [TIME_W-1:0] now);
        logic [PRESS_BIT-1:0] key_num;
        int                   slot;
        int                   row;
        int                   col;
        int                   i;
        bit                   in_range;
        logic [TIME_W-1:0]    held_for;
        logic [TIME_W-1:0]    since_rep;
        in_range = 1'b1;
        slot     = 0;
        if (has_code) begin
            key_num = code[PRESS_BIT-1:0];
            if (key_num >= GPIO_CODE_MIN) begin
                slot = int'(gpio_slot);
            end
            else if (key_num == '0) begin
                in_range = 1'b0;
            end
            else begin
                row = (int'(key_num) - 1) / int'(MATRIX_PITCH);
                col = (int'(key_num) - 1) % int'(MATRIX_PITCH);
                if (row >= ROWS || col >= COLS)
                    in_range = 1'b0;
                else
                    slot = col + row * COLS;
            end
            if (slot >= NSLOT)
                in_range = 1'b0;
            if (in_range) begin
                if (code[PRESS_BIT]) begin
                    press_t[slot]  = now;
                    repeat_t[slot] = now;
                    key_down[slot] = 1'b1;
                end
                else begin
                    key_down[slot] = 1'b0;
                end
            end
        end
        // Drop the whole scan on a key outside the matrix
        if (!in_range)
            return;

        for (i = 0; i < NSLOT; i++) begin
            if (key_down[i] != key_seen[i]) begin
                if (key_down[i]) begin
                    long_done[i] = 1'b0;
                    stage_beat(i, EV_PRESS);
                end
                else begin
                    stage_beat(i, EV_RELEASE);
                    held_for = now - press_t[i];
                    if (held_for < TIME_W'(long_thr))
                        stage_beat(i, EV_SHORT);
                end
                key_seen[i] = key_down[i];
            end
            else if (key_down[i]) begin
                since_rep = now - repeat_t[i];
                if (since_rep > TIME_W'(rep_int)) begin
                    repeat_t[i] = now;
                    stage_beat(i, EV_REPEAT);
                end
                held_for = now - press_t[i];
                if (held_for >= TIME_W'(long_thr) && !long_done[i]) begin
                    long_done[i] = 1'b1;
                    stage_beat(i, EV_LONG);
                end
            end
        end

        if (have_staged) begin
            staged.last = 1'b1;
            pending_events.push_back(staged);
            have_staged = 1'b0;
        end
    endtask

    // Compare one result beat with the oldest predicted event
    task automatic check_beat();
        event_beat_t want;
        beat_count++;
        if (pending_events.size() == 0) begin
            $error("result beat with nothing expected: key_index %0d event_kind %0d last %0d",
                   key_index, event_kind, last);
            err_count++;
        end
        else begin
            want = pending_events.pop_front();
            if (key_index !== want.idx) begin
                $error("key_index: expected %0d, got %0d", want.idx, key_index);
                err_count++;
            end
            if (event_kind !== want.kind) begin
                $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
                err_count++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, last);
                err_count++;
            end
        end
    endtask

    // Track registers, scans and results at each clock edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            long_thr  = LONG_THR_RST;
            rep_int   = REP_INT_RST;
            gpio_slot = GPIO_IDX_RST;
            for (int i = 0; i < NSLOT; i++) begin
                press_t[i]   = '0;
                repeat_t[i]  = '0;
                key_down[i]  = 1'b0;
                key_seen[i]  = 1'b0;
                long_done[i] = 1'b0;
            end
            pending_events.delete();
            have_staged = 1'b0;
            outstanding <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LONG_THR: long_thr  = cfg_wdata;
                    CFG_REP_INT:  rep_int   = cfg_wdata;
                    CFG_GPIO_IDX: gpio_slot = cfg_wdata[GPIO_W-1:0];
                    default: ;
                endcase
            end
            // Results never stem from a scan taken at the same edge, so check first
            if (out_valid && out_ready)
                check_beat();
            if (in_valid && in_ready)
                predict_events(cmd, event_code, time_ms);
            outstanding <= pending_events.size();
        end
        mismatches <= err_count;
        beats_seen <= beat_count;
    end

endmodule

### tb/testbench.sv
// Testbench top: clock, reset, scan stimulus, result back-pressure, watchdog and verdict.
module testbench;
    import kper_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS            = 5;
    localparam int COLS            = 6;
    localparam int NSLOT           = (ROWS * COLS > 32) ? 32 : ROWS * COLS;
    localparam int SETTLE_CYCLES   = 2 * (NSLOT + 4);
    localparam int LONG_HOLD       = 600;
    localparam int STALL_LIMIT     = 4000;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 36;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              cfg_we     = 1'b0;
    logic [1:0]        cfg_index  = CFG_LONG_THR;
    logic [THR_W-1:0]  cfg_wdata  = '0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic              cmd        = 1'b0;
    logic [CODE_W-1:0] event_code = '0;
    logic [TIME_W-1:0] time_ms    = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic [KEY_W-1:0]  key_index;
    logic [2:0]        event_kind;
    logic              last;

    int mismatches;
    int outstanding;
    int beats_seen;

    // Stimulus bookkeeping
    logic [TIME_W-1:0] now_ms       = '0;
    logic [GPIO_W-1:0] gpio_cur     = GPIO_IDX_RST;
    bit                held [32];
    bit                calm         = 1'b0;
    int                hold_reqs    = 0;
    int                scans_sent   = 0;
    int                settings_run = 1;

    always #5 clk = ~clk;

    keypad_event_repeat_long_press_top #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .event_code(event_code),
        .time_ms   (time_ms),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .key_index (key_index),
        .event_kind(event_kind),
        .last      (last)
    );

    keypad_event_checker #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) events_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .event_code (event_code),
        .time_ms    (time_ms),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .key_index  (key_index),
        .event_kind (event_kind),
        .last       (last),
        .mismatches (mismatches),
        .outstanding(outstanding),
        .beats_seen (beats_seen)
    );

    // Mostly short idle gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [CODE_W-1:0] key_code(input logic pressed, input int row,
                                                   input int col);
        return {pressed, 7'(row * int'(MATRIX_PITCH) + col + 1)};
    endfunction

    // Offer one scan beat, hold it until taken, then idle for a random gap
    task automatic send_scan(input logic has_code, input logic [CODE_W-1:0] code,
                             input logic [TIME_W-1:0] t);
        int gap;
        in_valid   <= 1'b1;
        cmd        <= has_code;
        event_code <= code;
        time_ms    <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        scans_sent++;
        gap = calm ? 0 : gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering, wait for every predicted event, then let a silent scan finish
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all registers while the block is idle
    task automatic apply_setting(input logic [THR_W-1:0] thr, input logic [THR_W-1:0] rep,
                                 input logic [THR_W-1:0] gpio_word, input bit poke_spare);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LONG_THR;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_index <= CFG_REP_INT;
        cfg_wdata <= rep;
        @(posedge clk);
        cfg_index <= CFG_GPIO_IDX;
        cfg_wdata <= gpio_word;
        @(posedge clk);
        if (poke_spare) begin
            cfg_index <= CFG_SPARE;
            cfg_wdata <= '1;
            @(posedge clk);
        end
        cfg_we   <= 1'b0;
        gpio_cur  = gpio_word[GPIO_W-1:0];
        settings_run++;
    endtask

    // Result side back-pressure
    initial begin : receiver
        int span;
        int holds_done;
        holds_done = 0;
        @(posedge clk);
        forever begin
            if (hold_reqs != holds_done) begin
                holds_done++;
                out_ready <= 1'b0;
                span = LONG_HOLD;
            end
            else if (calm) begin
                out_ready <= 1'b1;
                span = 1;
            end
            else if ($urandom_range(0, 2) != 0) begin
                out_ready <= 1'b1;
                span = $urandom_range(1, 12);
            end
            else begin
                out_ready <= 1'b0;
                span = gap_len() + 1;
            end
            repeat (span) @(posedge clk);
        end
    end

    // End the run when no beat moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no beat moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int                   phase;
        int                   n;
        int                   r;
        int                   slot;
        logic                 pressed;
        logic [PRESS_BIT-1:0] key_num;
        logic [THR_W-1:0]     thr;
        logic [THR_W-1:0]     rep;
        logic [THR_W-1:0]     gpio_word;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed scans under the reset register values
        send_scan(1'b0, 8'h00, 32'd0);
        send_scan(1'b1, key_code(1'b1, 0, 0), 32'd10);
        send_scan(1'b0, 8'hFF, 32'd100);
        send_scan(1'b0, 8'h00, 32'd211);
        send_scan(1'b0, 8'h00, 32'd411);
        send_scan(1'b0, 8'h00, 32'd510);
        send_scan(1'b1, key_code(1'b0, 0, 0), 32'd520);
        send_scan(1'b1, key_code(1'b1, ROWS - 1, COLS - 1), 32'd600);
        send_scan(1'b1, key_code(1'b0, ROWS - 1, COLS - 1), 32'd1099);
        send_scan(1'b1, {1'b1, GPIO_CODE_MIN}, 32'd1200);
        send_scan(1'b1, 8'h7F, 32'd1300);
        // key number zero, then keys off the matrix
        send_scan(1'b1, 8'h80, 32'd1400);
        send_scan(1'b1, 8'h00, 32'd1401);
        send_scan(1'b1, key_code(1'b1, 0, COLS), 32'd1402);
        send_scan(1'b1, key_code(1'b1, ROWS, 0), 32'd1403);
        send_scan(1'b1, key_code(1'b1, 9, 5), 32'd1404);
        // several keys held through repeat and long
        send_scan(1'b1, key_code(1'b1, 1, 1), 32'd2000);
        send_scan(1'b1, key_code(1'b1, 2, 3), 32'd2001);
        send_scan(1'b1, key_code(1'b1, 4, 0), 32'd2002);
        send_scan(1'b0, 8'h00, 32'd2700);
        // time wraps past two to the 32
        send_scan(1'b0, 8'h00, 32'hFFFF_FF00);
        send_scan(1'b1, key_code(1'b1, 3, 2), 32'hFFFF_FFF0);
        send_scan(1'b1, key_code(1'b0, 1, 1), 32'h0000_0100);
        send_scan(1'b1, 8'hFF, 32'hFFFF_FFFF);
        now_ms = 32'hFFFF_FFFF;

        // Random phases, each under its own register setting
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    thr = 16'd1;  rep = 16'd1;  gpio_word = 16'd0;
                end
                1: begin
                    thr = '1;  rep = '1;  gpio_word = THR_W'(NSLOT - 1);
                end
                2: begin
                    // zero thresholds, GPIO slot past the matrix, upper bits dropped
                    thr = '0;  rep = '0;  gpio_word = '1;
                end
                default: begin
                    thr       = THR_W'($urandom_range(20, 800));
                    rep       = THR_W'($urandom_range(5, 300));
                    gpio_word = THR_W'($urandom);
                end
            endcase
            apply_setting(thr, rep, gpio_word, phase == 1);
            calm = (phase == 4);

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Receiver holds off while scans keep coming
                if (phase == 3 && n == 8)
                    hold_reqs++;

                // Advance time, mostly by small steps
                r = $urandom_range(0, 99);
                if (r < 5)
                    now_ms = $urandom;
                else if (r < 15)
                    now_ms += $urandom_range(0, 70000);
                else if (r < 30)
                    now_ms += $urandom_range(0, 1000);
                else
                    now_ms += $urandom_range(0, 300);

                r = $urandom_range(0, 99);
                if (r < 80 && r >= 45) begin
                    // plain scan; the code is noise
                    send_scan(1'b0, CODE_W'($urandom), now_ms);
                end
                else if (r < 90) begin
                    if ($urandom_range(0, 9) == 0) begin
                        slot    = int'(gpio_cur);
                        key_num = 7'($urandom_range(int'(GPIO_CODE_MIN), 127));
                    end
                    else begin
                        slot    = $urandom_range(0, NSLOT - 1);
                        key_num = 7'((slot / COLS) * int'(MATRIX_PITCH) + slot % COLS + 1);
                    end
                    // well-formed toggles mostly, double press or stray release otherwise
                    if (r < 45 && slot < NSLOT)
                        pressed = !held[slot];
                    else
                        pressed = 1'($urandom_range(0, 1));
                    held[slot] = pressed;
                    send_scan(1'b1, {pressed, key_num}, now_ms);
                end
                else begin
                    send_scan(1'b1, CODE_W'($urandom), now_ms);
                end
            end
            calm = 1'b0;
        end

        drain();
        $display("Covered %0d scans under %0d register settings: field limits, key zero,",
                 scans_sent, settings_run);
        $display("off-matrix and GPIO keys, time wrap; %0d result beats checked in order.",
                 beats_seen);
        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end
        else begin
            if (outstanding != 0)
                $error("%0d predicted events never arrived", outstanding);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
design/kper_pkg.sv
design/kper_slot_dec.sv
design/kper_emit.sv
design/keypad_event_repeat_long_press_top.sv
tb/keypad_event_checker.sv
tb/testbench.sv
